// ===== design/dlpd_pkg.sv =====
package dlpd_pkg;

	typedef struct packed {
		logic [7:0]        min_insn_length;
		logic              default_stmt;
		logic signed [7:0] line_base;
		logic [7:0]        line_range;
		logic [7:0]        opcode_base;
		logic              wide_address;
	} cfg_t;

	localparam logic [2:0] CFG_MIN_INSN_LENGTH = 3'd0;
	localparam logic [2:0] CFG_DEFAULT_STMT    = 3'd1;
	localparam logic [2:0] CFG_LINE_BASE       = 3'd2;
	localparam logic [2:0] CFG_LINE_RANGE      = 3'd3;
	localparam logic [2:0] CFG_OPCODE_BASE     = 3'd4;
	localparam logic [2:0] CFG_WIDE_ADDRESS    = 3'd5;

	localparam logic [7:0] OP_EXTENDED       = 8'd0;
	localparam logic [7:0] OP_COPY           = 8'd1;
	localparam logic [7:0] OP_ADVANCE_PC     = 8'd2;
	localparam logic [7:0] OP_ADVANCE_LINE   = 8'd3;
	localparam logic [7:0] OP_SET_FILE       = 8'd4;
	localparam logic [7:0] OP_SET_COLUMN     = 8'd5;
	localparam logic [7:0] OP_NEGATE_STMT    = 8'd6;
	localparam logic [7:0] OP_SET_BB         = 8'd7;
	localparam logic [7:0] OP_CONST_ADD_PC   = 8'd8;
	localparam logic [7:0] OP_FIXED_ADV_PC   = 8'd9;
	localparam logic [7:0] OP_PROLOGUE_END   = 8'd10;
	localparam logic [7:0] OP_EPILOGUE_BEGIN = 8'd11;
	localparam logic [7:0] OP_SET_ISA        = 8'd12;
	localparam logic [7:0] OP_CONST_255      = 8'd255;

	localparam logic [7:0] EXT_END_SEQUENCE = 8'd1;
	localparam logic [7:0] EXT_SET_ADDRESS  = 8'd2;
	localparam logic [7:0] EXT_DEFINE_FILE  = 8'd3;

	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_STD     = 2'd1;
	localparam logic [1:0] ERR_EXT     = 2'd2;

	localparam int FL_STMT = 0;
	localparam int FL_BB   = 1;
	localparam int FL_PEND = 2;
	localparam int FL_EBEG = 3;

	typedef enum logic [2:0] {
		PH_OPCODE,
		PH_LEB,
		PH_FIXED,
		PH_EXT_LEN,
		PH_EXT_OP,
		PH_EXT_SKIP
	} phase_t;

	typedef enum logic [3:0] {
		K_NONE,
		K_SPECIAL,
		K_COPY,
		K_NEGSTMT,
		K_SETBB,
		K_CONSTADD,
		K_PEND,
		K_EBEG,
		K_ADVPC,
		K_ADVLINE,
		K_FILE,
		K_COLUMN,
		K_ISA,
		K_FIXPC,
		K_SETADDR,
		K_ENDSEQ
	} cmd_kind_t;

	typedef struct packed {
		logic        rst;
		logic        instr;
		cmd_kind_t   kind;
		logic [63:0] opnd;
		logic [1:0]  err;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ROW,
		BK_DIV,
		BK_MUL,
		BK_ADD
	} bk_state_t;

endpackage

// ===== design/dwarf_line_program_decoder_unit.sv =====
// channel  | handshake        | payload
// input    | push / full      | prog_byte, seq_restart
// result   | empty / pop      | row_* fields, op_error
// config   | wr_en            | wr_index, wr_data
// one byte is taken per cycle while the command queue has room
// each row passes the back-end idle and row states, then advance_pc takes
// one multiply and one add, special and const_add_pc an 8-step line_range
// divider before those; a restart byte that ends no instruction is popped
// with no row, other bytes that end no instruction produce no command
// reset clears the line registers, parser and both queues
module dwarf_line_program_decoder_unit #(
	parameter int ADDR_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           prog_byte,
	input  logic                 seq_restart,
	output logic                 empty,
	input  logic                 pop,
	output logic [ADDR_BITS-1:0] row_address,
	output logic [31:0]          row_line,
	output logic [31:0]          row_file,
	output logic [31:0]          row_column,
	output logic [31:0]          row_isa,
	output logic                 row_is_stmt,
	output logic                 row_basic_block,
	output logic                 row_end_seq,
	output logic                 row_prologue_end,
	output logic                 row_epilogue_begin,
	output logic [1:0]           op_error,
	input  logic                 wr_en,
	input  logic [2:0]           wr_index,
	input  logic [7:0]           wr_data
);
	localparam int ROW_W = ADDR_BITS + 135;

	dlpd_pkg::cfg_t cfg_q;
	dlpd_pkg::cmd_t cmd_in, cmd_out;
	logic           cmd_push, cmd_full, cmd_empty, cmd_pop, accept;
	logic           row_full, row_push;
	logic [ROW_W-1:0] row_in, row_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_insn_length <= 8'd1;
			cfg_q.default_stmt    <= 1'b1;
			cfg_q.line_base       <= -8'sd5;
			cfg_q.line_range      <= 8'd14;
			cfg_q.opcode_base     <= 8'd13;
			cfg_q.wide_address    <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				dlpd_pkg::CFG_MIN_INSN_LENGTH: cfg_q.min_insn_length <= wr_data;
				dlpd_pkg::CFG_DEFAULT_STMT:    cfg_q.default_stmt    <= wr_data[0];
				dlpd_pkg::CFG_LINE_BASE:       cfg_q.line_base       <= wr_data;
				dlpd_pkg::CFG_LINE_RANGE:      cfg_q.line_range      <= wr_data;
				dlpd_pkg::CFG_OPCODE_BASE:     cfg_q.opcode_base     <= wr_data;
				dlpd_pkg::CFG_WIDE_ADDRESS:    cfg_q.wide_address    <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	dlpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.prog_byte   (prog_byte),
		.seq_restart (seq_restart),
		.cfg         (cfg_q),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	dlpd_fifo #(.W($bits(dlpd_pkg::cmd_t)), .DEPTH(2)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	dlpd_back #(.ADDR_BITS(ADDR_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.row_full  (row_full),
		.row_push  (row_push),
		.row_data  (row_in)
	);

	dlpd_fifo #(.W(ROW_W), .DEPTH(2)) u_row_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (row_push),
		.wdata  (row_in),
		.full   (row_full),
		.rd     (pop),
		.rdata  (row_out),
		.empty  (empty)
	);

	assign {row_address, row_line, row_file, row_column, row_isa, row_is_stmt,
		row_basic_block, row_end_seq, row_prologue_end, row_epilogue_begin,
		op_error} = row_out;
endmodule

// ===== design/dlpd_fifo.sv =====
module dlpd_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== design/dlpd_front.sv =====
module dlpd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    prog_byte,
	input  logic          seq_restart,
	input  dlpd_pkg::cfg_t cfg,
	output logic          cmd_push,
	output dlpd_pkg::cmd_t cmd
);
	dlpd_pkg::phase_t phase_q, phase_n, ph;
	logic [7:0]  cur_q, cur_n, cur;
	logic [7:0]  ext_q, ext_n, ext;
	logic [7:0]  bl_q, bl_n, bl;
	logic [63:0] acc_q, acc_n, acc;
	logic [6:0]  sc_q, sc_n, sc;

	always_comb begin
		ph  = seq_restart ? dlpd_pkg::PH_OPCODE : phase_q;
		cur = seq_restart ? '0 : cur_q;
		ext = seq_restart ? '0 : ext_q;
		bl  = seq_restart ? '0 : bl_q;
		acc = seq_restart ? '0 : acc_q;
		sc  = seq_restart ? '0 : sc_q;
		phase_n = ph;
		cur_n = cur;
		ext_n = ext;
		bl_n  = bl;
		acc_n = acc;
		sc_n  = sc;
		cmd.rst   = seq_restart;
		cmd.instr = 1'b0;
		cmd.kind  = dlpd_pkg::K_NONE;
		cmd.opnd  = '0;
		cmd.err   = dlpd_pkg::ERR_OK;
		unique case (ph)
			dlpd_pkg::PH_LEB: begin
				if (!sc[6]) begin
					acc_n = acc | ({57'b0, prog_byte[6:0]} << sc[5:0]);
					sc_n  = sc + 7'd7;
				end
				if (!prog_byte[7]) begin
					if (cur == dlpd_pkg::OP_ADVANCE_LINE && prog_byte[6] && !sc_n[6]) begin
						acc_n = acc_n | (~64'b0 << sc_n[5:0]);
					end
					cmd.instr = 1'b1;
					cmd.opnd  = acc_n;
					case (cur)
						dlpd_pkg::OP_ADVANCE_PC:   cmd.kind = dlpd_pkg::K_ADVPC;
						dlpd_pkg::OP_ADVANCE_LINE: cmd.kind = dlpd_pkg::K_ADVLINE;
						dlpd_pkg::OP_SET_FILE:     cmd.kind = dlpd_pkg::K_FILE;
						dlpd_pkg::OP_SET_COLUMN:   cmd.kind = dlpd_pkg::K_COLUMN;
						default:                   cmd.kind = dlpd_pkg::K_ISA;
					endcase
					phase_n = dlpd_pkg::PH_OPCODE;
				end
			end
			dlpd_pkg::PH_FIXED: begin
				if (!sc[6]) begin
					acc_n = acc | ({56'b0, prog_byte} << sc[5:0]);
					sc_n  = sc + 7'd8;
				end
				if (bl != '0) begin
					bl_n = bl - 8'd1;
				end
				if (bl_n == '0) begin
					cmd.instr = 1'b1;
					cmd.opnd  = acc_n;
					cmd.kind  = (cur == dlpd_pkg::OP_FIXED_ADV_PC) ? dlpd_pkg::K_FIXPC
						: dlpd_pkg::K_SETADDR;
					phase_n = dlpd_pkg::PH_OPCODE;
				end
			end
			dlpd_pkg::PH_EXT_LEN: begin
				bl_n = prog_byte;
				if (prog_byte == '0) begin
					cmd.instr = 1'b1;
					cmd.err   = dlpd_pkg::ERR_EXT;
					phase_n   = dlpd_pkg::PH_OPCODE;
				end else begin
					phase_n = dlpd_pkg::PH_EXT_OP;
				end
			end
			dlpd_pkg::PH_EXT_OP: begin
				ext_n = prog_byte;
				if (prog_byte == dlpd_pkg::EXT_END_SEQUENCE) begin
					cmd.instr = 1'b1;
					cmd.kind  = dlpd_pkg::K_ENDSEQ;
					phase_n   = dlpd_pkg::PH_OPCODE;
				end else if (prog_byte == dlpd_pkg::EXT_SET_ADDRESS) begin
					phase_n = dlpd_pkg::PH_FIXED;
					acc_n   = '0;
					sc_n    = '0;
					bl_n    = cfg.wide_address ? 8'd8 : 8'd4;
				end else begin
					bl_n = bl - 8'd1;
					if (bl_n == '0) begin
						cmd.instr = 1'b1;
						cmd.err   = (prog_byte == dlpd_pkg::EXT_DEFINE_FILE) ? dlpd_pkg::ERR_OK
							: dlpd_pkg::ERR_EXT;
						phase_n   = dlpd_pkg::PH_OPCODE;
					end else begin
						phase_n = dlpd_pkg::PH_EXT_SKIP;
					end
				end
			end
			dlpd_pkg::PH_EXT_SKIP: begin
				if (bl != '0) begin
					bl_n = bl - 8'd1;
				end
				if (bl_n == '0) begin
					cmd.instr = 1'b1;
					cmd.err   = (ext == dlpd_pkg::EXT_DEFINE_FILE) ? dlpd_pkg::ERR_OK
						: dlpd_pkg::ERR_EXT;
					phase_n   = dlpd_pkg::PH_OPCODE;
				end
			end
			default: begin
				cur_n = prog_byte;
				if (prog_byte >= cfg.opcode_base) begin
					cmd.instr = 1'b1;
					cmd.kind  = dlpd_pkg::K_SPECIAL;
					cmd.opnd  = {56'b0, prog_byte - cfg.opcode_base};
				end else begin
					unique case (prog_byte)
						dlpd_pkg::OP_EXTENDED: phase_n = dlpd_pkg::PH_EXT_LEN;
						dlpd_pkg::OP_ADVANCE_PC, dlpd_pkg::OP_ADVANCE_LINE,
						dlpd_pkg::OP_SET_FILE, dlpd_pkg::OP_SET_COLUMN,
						dlpd_pkg::OP_SET_ISA: begin
							phase_n = dlpd_pkg::PH_LEB;
							acc_n = '0;
							sc_n  = '0;
							bl_n  = '0;
						end
						dlpd_pkg::OP_FIXED_ADV_PC: begin
							phase_n = dlpd_pkg::PH_FIXED;
							acc_n = '0;
							sc_n  = '0;
							bl_n  = 8'd2;
						end
						dlpd_pkg::OP_COPY: begin
							cmd.instr = 1'b1;
							cmd.kind  = dlpd_pkg::K_COPY;
						end
						dlpd_pkg::OP_NEGATE_STMT: begin
							cmd.instr = 1'b1;
							cmd.kind  = dlpd_pkg::K_NEGSTMT;
						end
						dlpd_pkg::OP_SET_BB: begin
							cmd.instr = 1'b1;
							cmd.kind  = dlpd_pkg::K_SETBB;
						end
						dlpd_pkg::OP_CONST_ADD_PC: begin
							cmd.instr = 1'b1;
							cmd.kind  = dlpd_pkg::K_CONSTADD;
							cmd.opnd  = {56'b0, dlpd_pkg::OP_CONST_255 - cfg.opcode_base};
						end
						dlpd_pkg::OP_PROLOGUE_END: begin
							cmd.instr = 1'b1;
							cmd.kind  = dlpd_pkg::K_PEND;
						end
						dlpd_pkg::OP_EPILOGUE_BEGIN: begin
							cmd.instr = 1'b1;
							cmd.kind  = dlpd_pkg::K_EBEG;
						end
						default: begin
							cmd.instr = 1'b1;
							cmd.err   = dlpd_pkg::ERR_STD;
						end
					endcase
				end
			end
		endcase
		cmd_push = accept && (cmd.rst || cmd.instr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dlpd_pkg::PH_OPCODE;
			cur_q   <= '0;
			ext_q   <= '0;
			bl_q    <= '0;
			acc_q   <= '0;
			sc_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			cur_q   <= cur_n;
			ext_q   <= ext_n;
			bl_q    <= bl_n;
			acc_q   <= acc_n;
			sc_q    <= sc_n;
		end
	end
endmodule

// ===== design/dlpd_back.sv =====
module dlpd_back #(
	parameter int ADDR_BITS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dlpd_pkg::cfg_t            cfg,
	input  logic                      cmd_empty,
	input  dlpd_pkg::cmd_t            cmd,
	output logic                      cmd_pop,
	input  logic                      row_full,
	output logic                      row_push,
	output logic [ADDR_BITS+135-1:0]  row_data
);
	dlpd_pkg::bk_state_t state_q, state_n;
	dlpd_pkg::cmd_t      cmd_q;

	logic [ADDR_BITS-1:0] addr_q;
	logic [31:0] line_q, file_q, col_q, isa_q;
	logic [3:0]  flags_q;
	logic [7:0]  dvd_q, dsh_q, quo_q, rem_q;
	logic [2:0]  cnt_q;
	logic [63:0] prod_q;
	logic [8:0]  rem_sh;
	logic        ge;
	logic [7:0]  rem_n, q_eff, r_eff;
	logic [63:0] mul_a;
	logic [3:0]  reset_flags;

	assign reset_flags = {3'b0, cfg.default_stmt};
	assign rem_sh = {rem_q, dsh_q[7]};
	assign ge     = rem_sh >= {1'b0, cfg.line_range};
	assign rem_n  = ge ? 8'(rem_sh - {1'b0, cfg.line_range}) : rem_sh[7:0];
	assign q_eff  = (cfg.line_range == '0) ? '0 : quo_q;
	assign r_eff  = (cfg.line_range == '0) ? dvd_q : rem_q;
	assign mul_a  = (cmd_q.kind == dlpd_pkg::K_ADVPC) ? cmd_q.opnd : {56'b0, q_eff};

	assign row_data = {addr_q, line_q, file_q, col_q, isa_q,
		flags_q[dlpd_pkg::FL_STMT], flags_q[dlpd_pkg::FL_BB],
		cmd_q.kind == dlpd_pkg::K_ENDSEQ,
		flags_q[dlpd_pkg::FL_PEND], flags_q[dlpd_pkg::FL_EBEG], cmd_q.err};

	always_comb begin
		state_n  = state_q;
		cmd_pop  = 1'b0;
		row_push = 1'b0;
		unique case (state_q)
			dlpd_pkg::BK_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					if (cmd.instr) begin
						state_n = dlpd_pkg::BK_ROW;
					end
				end
			end
			dlpd_pkg::BK_ROW: begin
				if (!row_full) begin
					row_push = 1'b1;
					case (cmd_q.kind)
						dlpd_pkg::K_SPECIAL, dlpd_pkg::K_CONSTADD: state_n = dlpd_pkg::BK_DIV;
						dlpd_pkg::K_ADVPC: state_n = dlpd_pkg::BK_MUL;
						default:           state_n = dlpd_pkg::BK_IDLE;
					endcase
				end
			end
			dlpd_pkg::BK_DIV: begin
				if (cnt_q == 3'd7) begin
					state_n = dlpd_pkg::BK_MUL;
				end
			end
			dlpd_pkg::BK_MUL: state_n = dlpd_pkg::BK_ADD;
			default:          state_n = dlpd_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlpd_pkg::BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dlpd_pkg::BK_ROW && !row_full) begin
			dvd_q <= cmd_q.opnd[7:0];
			dsh_q <= cmd_q.opnd[7:0];
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (state_q == dlpd_pkg::BK_DIV) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[6:0], ge};
			dsh_q <= {dsh_q[6:0], 1'b0};
			cnt_q <= cnt_q + 3'd1;
		end
		if (state_q == dlpd_pkg::BK_MUL) begin
			prod_q <= mul_a * {56'b0, cfg.min_insn_length};
		end
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			line_q  <= 32'd1;
			file_q  <= 32'd1;
			col_q   <= '0;
			isa_q   <= '0;
			flags_q <= 4'd1;
		end else begin
			unique case (state_q)
				dlpd_pkg::BK_IDLE: begin
					if (cmd_pop && cmd.rst) begin
						addr_q  <= '0;
						line_q  <= 32'd1;
						file_q  <= 32'd1;
						col_q   <= '0;
						isa_q   <= '0;
						flags_q <= reset_flags;
					end
				end
				dlpd_pkg::BK_ROW: begin
					if (!row_full) begin
						case (cmd_q.kind)
							dlpd_pkg::K_COPY:    flags_q <= flags_q & 4'b0001;
							dlpd_pkg::K_NEGSTMT: flags_q[dlpd_pkg::FL_STMT] <= !flags_q[dlpd_pkg::FL_STMT];
							dlpd_pkg::K_SETBB:   flags_q[dlpd_pkg::FL_BB] <= 1'b1;
							dlpd_pkg::K_PEND:    flags_q[dlpd_pkg::FL_PEND] <= 1'b1;
							dlpd_pkg::K_EBEG:    flags_q[dlpd_pkg::FL_EBEG] <= 1'b1;
							dlpd_pkg::K_ADVLINE: line_q <= line_q + cmd_q.opnd[31:0];
							dlpd_pkg::K_FILE:    file_q <= cmd_q.opnd[31:0];
							dlpd_pkg::K_COLUMN:  col_q <= cmd_q.opnd[31:0];
							dlpd_pkg::K_ISA:     isa_q <= cmd_q.opnd[31:0];
							dlpd_pkg::K_FIXPC:   addr_q <= addr_q + ADDR_BITS'(cmd_q.opnd[15:0]);
							dlpd_pkg::K_SETADDR: addr_q <= cmd_q.opnd[ADDR_BITS-1:0];
							dlpd_pkg::K_ENDSEQ: begin
								addr_q  <= '0;
								line_q  <= 32'd1;
								file_q  <= 32'd1;
								col_q   <= '0;
								isa_q   <= '0;
								flags_q <= reset_flags;
							end
							default: ;
						endcase
					end
				end
				dlpd_pkg::BK_ADD: begin
					addr_q <= addr_q + prod_q[ADDR_BITS-1:0];
					if (cmd_q.kind == dlpd_pkg::K_SPECIAL) begin
						line_q  <= line_q + 32'(cfg.line_base) + {24'b0, r_eff};
						flags_q <= flags_q & 4'b0001;
					end
				end
				default: ;
			endcase
		end
	end

	a_row_space: assert property (@(posedge clk) disable iff (!arst_n)
		row_push |-> !row_full) else $error("row written into a full queue");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dlpd_pkg::BK_DIV && cnt_q == 3'd7) |=> state_q == dlpd_pkg::BK_MUL)
		else $error("divider did not hand over after eight steps");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.rst) |=> (line_q == 32'd1 && file_q == 32'd1))
		else $error("restart did not reset the line registers");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> state_q == dlpd_pkg::BK_IDLE)
		else $error("command taken while busy");
endmodule

// ===== verif/dlpd_row_checker.sv =====
`timescale 1ns / 1ps

module dlpd_row_checker
	import dlpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  prog_byte,
	input  logic        seq_restart,
	input  logic        empty,
	input  logic        pop,
	input  logic [63:0] row_address,
	input  logic [31:0] row_line,
	input  logic [31:0] row_file,
	input  logic [31:0] row_column,
	input  logic [31:0] row_isa,
	input  logic        row_is_stmt,
	input  logic        row_basic_block,
	input  logic        row_end_seq,
	input  logic        row_prologue_end,
	input  logic        row_epilogue_begin,
	input  logic [1:0]  op_error,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [7:0]  wr_data,
	output int          fails,
	output int          pending,
	output int          rows_seen
);

	typedef struct packed {
		logic [63:0] address;
		logic [31:0] line;
		logic [31:0] file;
		logic [31:0] column;
		logic [31:0] isa;
		logic        is_stmt;
		logic        basic_block;
		logic        end_seq;
		logic        prologue_end;
		logic        epilogue_begin;
		logic [1:0]  err;
	} line_row_t;

	line_row_t   rows_due[$];
	cfg_t        cfg;
	logic [63:0] addr_r, acc;
	logic [31:0] line_r, file_r, col_r, isa_r;
	logic [3:0]  flags;
	phase_t      phase;
	logic [7:0]  cur_op, ext_op, left;
	int          shamt;

	function automatic void regs_clear();
		addr_r = '0;
		line_r = 32'd1;
		file_r = 32'd1;
		col_r  = '0;
		isa_r  = '0;
		flags  = '0;
		flags[FL_STMT] = cfg.default_stmt;
	endfunction

	function automatic void parser_clear();
		phase  = PH_OPCODE;
		cur_op = '0;
		ext_op = '0;
		left   = '0;
		acc    = '0;
		shamt  = 0;
	endfunction

	function automatic void start_operand(phase_t ph, logic [7:0] n);
		phase = ph;
		acc   = '0;
		shamt = 0;
		left  = n;
	endfunction

	function automatic void emit(logic [1:0] err, logic endseq);
		line_row_t e;
		e.address        = addr_r;
		e.line           = line_r;
		e.file           = file_r;
		e.column         = col_r;
		e.isa            = isa_r;
		e.is_stmt        = flags[FL_STMT];
		e.basic_block    = flags[FL_BB];
		e.end_seq        = endseq;
		e.prologue_end   = flags[FL_PEND];
		e.epilogue_begin = flags[FL_EBEG];
		e.err            = err;
		rows_due.push_back(e);
	endfunction

	function automatic void split_range(logic [31:0] n, output logic [31:0] q,
			output logic [31:0] r);
		if (cfg.line_range == 0) begin
			q = 0;
			r = n;
		end else begin
			q = n / cfg.line_range;
			r = n % cfg.line_range;
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic rs);
		logic [31:0] q, r, lbi;
		if (rs) begin
			regs_clear();
			parser_clear();
		end
		case (phase)
			PH_LEB: begin
				if (shamt < 64) acc |= 64'(b[6:0]) << shamt;
				if (shamt < 64) shamt += 7;
				if (!b[7]) begin
					if (cur_op == OP_ADVANCE_LINE && b[6] && shamt < 64)
						acc |= ~64'd0 << shamt;
					emit(ERR_OK, 1'b0);
					case (cur_op)
						OP_ADVANCE_PC:   addr_r = addr_r + acc * 64'(cfg.min_insn_length);
						OP_ADVANCE_LINE: line_r = line_r + acc[31:0];
						OP_SET_FILE:     file_r = acc[31:0];
						OP_SET_COLUMN:   col_r = acc[31:0];
						default:         isa_r = acc[31:0];
					endcase
					phase = PH_OPCODE;
				end
			end
			PH_FIXED: begin
				if (shamt < 64) acc |= 64'(b) << shamt;
				if (shamt < 64) shamt += 8;
				if (left > 0) left--;
				if (left == 0) begin
					emit(ERR_OK, 1'b0);
					if (cur_op == OP_FIXED_ADV_PC) addr_r = addr_r + {48'd0, acc[15:0]};
					else addr_r = acc;
					phase = PH_OPCODE;
				end
			end
			PH_EXT_LEN: begin
				left = b;
				if (b == 0) begin
					emit(ERR_EXT, 1'b0);
					phase = PH_OPCODE;
				end else begin
					phase = PH_EXT_OP;
				end
			end
			PH_EXT_OP: begin
				ext_op = b;
				if (b == EXT_END_SEQUENCE) begin
					emit(ERR_OK, 1'b1);
					regs_clear();
					phase = PH_OPCODE;
				end else if (b == EXT_SET_ADDRESS) begin
					start_operand(PH_FIXED, cfg.wide_address ? 8'd8 : 8'd4);
				end else begin
					left = left - 8'd1;
					if (left == 0) begin
						emit(b == EXT_DEFINE_FILE ? ERR_OK : ERR_EXT, 1'b0);
						phase = PH_OPCODE;
					end else begin
						phase = PH_EXT_SKIP;
					end
				end
			end
			PH_EXT_SKIP: begin
				if (left > 0) left--;
				if (left == 0) begin
					emit(ext_op == EXT_DEFINE_FILE ? ERR_OK : ERR_EXT, 1'b0);
					phase = PH_OPCODE;
				end
			end
			default: begin
				phase  = PH_OPCODE;
				cur_op = b;
				if (b >= cfg.opcode_base) begin
					split_range(32'(b - cfg.opcode_base), q, r);
					lbi = {{24{cfg.line_base[7]}}, cfg.line_base};
					emit(ERR_OK, 1'b0);
					addr_r = addr_r + 64'(q) * 64'(cfg.min_insn_length);
					line_r = line_r + lbi + r;
					flags  = flags & 4'b0001;
				end else begin
					case (b)
						OP_EXTENDED: phase = PH_EXT_LEN;
						OP_ADVANCE_PC, OP_ADVANCE_LINE, OP_SET_FILE, OP_SET_COLUMN,
						OP_SET_ISA: start_operand(PH_LEB, 8'd0);
						OP_FIXED_ADV_PC: start_operand(PH_FIXED, 8'd2);
						default: begin
							emit(b > OP_SET_ISA ? ERR_STD : ERR_OK, 1'b0);
							case (b)
								OP_COPY:           flags = flags & 4'b0001;
								OP_NEGATE_STMT:    flags[FL_STMT] = !flags[FL_STMT];
								OP_SET_BB:         flags[FL_BB] = 1'b1;
								OP_PROLOGUE_END:   flags[FL_PEND] = 1'b1;
								OP_EPILOGUE_BEGIN: flags[FL_EBEG] = 1'b1;
								OP_CONST_ADD_PC: begin
									split_range(32'(OP_CONST_255 - cfg.opcode_base), q, r);
									addr_r = addr_r + 64'(q) * 64'(cfg.min_insn_length);
								end
								default: ;
							endcase
						end
					endcase
				end
			end
		endcase
	endfunction

	function automatic void check_row();
		line_row_t got, want;
		got = {row_address, row_line, row_file, row_column, row_isa, row_is_stmt,
			row_basic_block, row_end_seq, row_prologue_end, row_epilogue_begin, op_error};
		rows_seen++;
		if (rows_due.size() == 0) begin
			fails++;
			if (fails <= 10) $display("unexpected row %p", got);
			return;
		end
		want = rows_due.pop_front();
		if (got !== want) begin
			fails++;
			if (fails <= 10) $display("row %0d mismatch\n  exp %p\n  got %p", rows_seen, want, got);
		end
	endfunction

	initial begin
		fails = 0;
		pending = 0;
		rows_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{min_insn_length: 8'd1, default_stmt: 1'b1, line_base: -8'sd5,
				line_range: 8'd14, opcode_base: 8'd13, wide_address: 1'b1};
			regs_clear();
			parser_clear();
			rows_due.delete();
		end else begin
			if (pop && !empty) check_row();
			if (wr_en) begin
				case (wr_index)
					CFG_MIN_INSN_LENGTH: cfg.min_insn_length = wr_data;
					CFG_DEFAULT_STMT:    cfg.default_stmt = wr_data[0];
					CFG_LINE_BASE:       cfg.line_base = wr_data;
					CFG_LINE_RANGE:      cfg.line_range = wr_data;
					CFG_OPCODE_BASE:     cfg.opcode_base = wr_data;
					CFG_WIDE_ADDRESS:    cfg.wide_address = wr_data[0];
					default: ;
				endcase
			end
			if (push && !full) decode_byte(prog_byte, seq_restart);
		end
		pending = rows_due.size();
	end

endmodule

// ===== verif/dwarf_line_program_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module dwarf_line_program_decoder_unit_tb;
	import dlpd_pkg::*;

	localparam int LIMIT = 600000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic [7:0]  prog_byte = '0;
	logic        seq_restart = 0;
	logic        pop = 0;
	logic        wr_en = 0;
	logic [2:0]  wr_index = '0;
	logic [7:0]  wr_data = '0;
	logic        full, empty;
	logic [63:0] row_address;
	logic [31:0] row_line, row_file, row_column, row_isa;
	logic        row_is_stmt, row_basic_block, row_end_seq, row_prologue_end;
	logic        row_epilogue_begin;
	logic [1:0]  op_error;
	int          fails, pending, rows_seen;
	int          cycles = 0;
	int          bytes_sent = 0;
	int          instrs_sent = 0;
	bit          calm = 0;
	logic [7:0]  cur_ob = 8'd13;
	logic        cur_wide = 1'b1;

	always #2 clk = ~clk;

	dwarf_line_program_decoder_unit i_dut (.*);

	dlpd_row_checker i_checker (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) pop <= calm || ($urandom_range(99) >= 28);

	task automatic send(input logic [7:0] b, input logic rs = 1'b0);
		bit ok;
		while (!calm && $urandom_range(99) < 28) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		prog_byte <= b;
		seq_restart <= rs;
		forever begin
			ok = !full;
			@(negedge clk);
			if (ok) break;
		end
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		if (idx == CFG_OPCODE_BASE) cur_ob = val;
		if (idx == CFG_WIDE_ADDRESS) cur_wide = val[0];
	endtask

	task automatic set_config(input logic [7:0] mil, input logic ds, input logic [7:0] lb,
			input logic [7:0] lr, input logic [7:0] ob, input logic wa);
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		write_reg(CFG_MIN_INSN_LENGTH, mil);
		write_reg(CFG_DEFAULT_STMT, {7'd0, ds});
		write_reg(CFG_LINE_BASE, lb);
		write_reg(CFG_LINE_RANGE, lr);
		write_reg(CFG_OPCODE_BASE, ob);
		write_reg(CFG_WIDE_ADDRESS, {7'd0, wa});
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_leb(input logic [7:0] op, input int n, input bit neg);
		send(op);
		for (int i = 0; i < n - 1; i++) send(8'h80 | 8'($urandom_range(127)));
		send({1'b0, neg, 6'($urandom_range(63))});
	endtask

	task automatic send_ext(input logic [7:0] len, input logic [7:0] sub);
		send(OP_EXTENDED);
		send(len);
		if (len == 0) return;
		send(sub);
		if (sub == EXT_SET_ADDRESS) begin
			repeat (cur_wide ? 8 : 4) send(8'($urandom));
		end else if (sub != EXT_END_SEQUENCE) begin
			repeat (int'(len) - 1) send(8'($urandom));
		end
	endtask

	task automatic send_instr();
		int k;
		logic [7:0] sub;
		k = $urandom_range(99);
		instrs_sent++;
		if (k < 30) send(8'($urandom_range(255, cur_ob)));
		else if (k < 48) send_leb(8'($urandom_range(OP_ADVANCE_PC, OP_SET_COLUMN)),
			$urandom_range(9) == 0 ? $urandom_range(12) + 1 : $urandom_range(3) + 1,
			$urandom_range(1));
		else if (k < 52) send_leb(OP_SET_ISA, $urandom_range(4) + 1, $urandom_range(1));
		else if (k < 64) begin
			case ($urandom_range(5))
				0: send(OP_COPY);
				1: send(OP_NEGATE_STMT);
				2: send(OP_SET_BB);
				3: send(OP_CONST_ADD_PC);
				4: send(OP_PROLOGUE_END);
				default: send(OP_EPILOGUE_BEGIN);
			endcase
		end else if (k < 70) begin
			send(OP_FIXED_ADV_PC);
			send(8'($urandom));
			send(8'($urandom));
		end else if (k < 78) send_ext(8'($urandom_range(255)), EXT_END_SEQUENCE);
		else if (k < 85) send_ext(8'($urandom_range(255)), EXT_SET_ADDRESS);
		else if (k < 90) send_ext(8'($urandom_range(6, 1)), EXT_DEFINE_FILE);
		else if (k < 94) begin
			sub = 8'($urandom_range(255, 4));
			if ($urandom_range(5) == 0) sub = 8'd0;
			send_ext(8'($urandom_range(5, 1)), sub);
		end else if (k < 96) send_ext(8'd0, 8'd0);
		else if (cur_ob > 8'd13) send(8'($urandom_range(cur_ob - 1, 13)));
		else send(OP_COPY);
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(99))
				0, 1, 2:         send(8'($urandom), 1'b1);
				3, 4, 5, 6, 7, 8,
				9, 10, 11:       send(8'($urandom));
				default:         send_instr();
			endcase
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: defaults, every opcode and edge operand
		send(8'd13);
		send(8'd255);
		send(OP_COPY);
		send(OP_NEGATE_STMT);
		send(OP_SET_BB);
		send(OP_PROLOGUE_END);
		send(OP_EPILOGUE_BEGIN);
		send(OP_CONST_ADD_PC);
		send_leb(OP_ADVANCE_PC, 10, 1'b1);
		send_leb(OP_ADVANCE_LINE, 1, 1'b1);
		send_leb(OP_ADVANCE_LINE, 11, 1'b0);
		send_leb(OP_SET_FILE, 5, 1'b1);
		send_leb(OP_SET_COLUMN, 1, 1'b0);
		send_leb(OP_SET_ISA, 3, 1'b1);
		send(OP_FIXED_ADV_PC); send(8'hff); send(8'hff);
		send_ext(8'd9, EXT_SET_ADDRESS);
		send_ext(8'd1, EXT_END_SEQUENCE);
		send_ext(8'd4, EXT_DEFINE_FILE);
		send_ext(8'd255, 8'd200);
		send_ext(8'd1, 8'd0);
		send_ext(8'd0, 8'd0);
		send(OP_SET_ISA);
		send(8'h00, 1'b1);
		send(8'd0); send(8'd1); send(EXT_END_SEQUENCE);
		instrs_sent += 24;

		set_config(8'd255, 1'b0, 8'h80, 8'd255, 8'd255, 1'b0);
		random_phase(35);
		calm = 1;
		set_config(8'd1, 1'b1, 8'h7f, 8'd1, 8'd1, 1'b1);
		random_phase(35);
		calm = 0;
		set_config(8'd4, 1'b1, 8'hfd, 8'd12, 8'd10, 1'b0);
		random_phase(30);
		set_config(8'd0, 1'b0, 8'h00, 8'd0, 8'd0, 1'b1);
		random_phase(30);
		set_config(8'd2, 1'b1, 8'hfb, 8'd14, 8'd40, 1'b1);
		random_phase(30);
		set_config(8'($urandom_range(255, 1)), 1'($urandom), 8'($urandom),
			8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)), 1'($urandom));
		random_phase(30);

		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("sent %0d program bytes (%0d instructions) over 7 settings", bytes_sent,
			instrs_sent);
		$display("checked %0d rows, %0d mismatches", rows_seen, fails);
		if (fails == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/dlpd_pkg.sv
design/dlpd_fifo.sv
design/dlpd_front.sv
design/dlpd_back.sv
design/dwarf_line_program_decoder_unit.sv
verif/dlpd_row_checker.sv
verif/dwarf_line_program_decoder_unit_tb.sv
